@@ src/fpba_pkg.sv @@
package fpba_pkg;

  // Fixed field widths of the request and response words
  localparam int unsigned ModeW  = 2;
  localparam int unsigned BytesW = 20;
  localparam int unsigned StyleW = 2;
  localparam int unsigned AddrW  = 12;
  localparam int unsigned StatW  = 3;

  // Allocate sizing: granules = (bytes + 7) / 8 + 1 needs 18 bits
  localparam int unsigned NeedW      = BytesW - 2;
  localparam int unsigned GranBytes  = 8;
  localparam int unsigned GranShift  = 3;

  localparam int unsigned DefCapacityGranules = 4096;
  localparam int unsigned DefPageBytes        = 4096;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

  typedef enum logic [StyleW-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_ARGS = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_BAD_PTR  = 3'd3,
    ST_NO_INIT  = 3'd4
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0]  block_address;
    logic [StyleW-1:0] fit_style;
    logic [BytesW-1:0] request_bytes;
    logic [ModeW-1:0]  mode;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    logic [StatW-1:0] status;
  } res_t;

endpackage

@@ src/fpba_mem.sv @@
module fpba_mem #(
  parameter int unsigned Depth = fpba_pkg::DefCapacityGranules,
  parameter int unsigned Width = 14
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fpba_ctrl.sv @@
module fpba_ctrl #(
  parameter int unsigned CapacityGranules = fpba_pkg::DefCapacityGranules,
  parameter int unsigned PageBytes        = fpba_pkg::DefPageBytes,
  localparam int unsigned AW = $clog2(CapacityGranules),
  localparam int unsigned SW = AW + 1,
  localparam int unsigned HW = SW + 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  fpba_pkg::req_t req_i,
  output logic           req_ready_o,
  output logic           res_valid_o,
  output fpba_pkg::res_t res_o,
  input  logic           res_take_i,
  output logic           we_o,
  output logic [AW-1:0]  waddr_o,
  output logic [HW-1:0]  wdata_o,
  output logic           re_o,
  output logic [AW-1:0]  raddr_o,
  input  logic [HW-1:0]  rdata_i
);
  import fpba_pkg::*;

  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned PageGranShift = PageShift - GranShift;
  localparam int unsigned MaxPages = CapacityGranules * GranBytes / PageBytes;
  localparam int unsigned PagesW = BytesW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_AL_WALK, S_AL_SPLIT, S_AL_MARK,
    S_FR_WALK, S_FR_NEXT, S_FR_WT, S_FR_WP, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [NeedW-1:0]   need_q, need_d;
  logic [StyleW-1:0]  style_q, style_d;
  logic [AddrW-1:0]   target_q, target_d;
  logic [SW-1:0]      g_q, g_d;
  logic [AW-1:0]      win_q, win_d;
  logic [SW-1:0]      wsz_q, wsz_d;
  logic               found_q, found_d;
  logic [AW-1:0]      prev_q, prev_d;
  logic [SW-1:0]      psz_q, psz_d;
  logic               pfree_q, pfree_d;
  logic               hprev_q, hprev_d;
  logic [SW-1:0]      tsz_q, tsz_d;
  logic               init_q, init_d;
  logic [SW-1:0]      end_q, end_d;
  logic [StatW-1:0]   status_q, status_d;
  logic [AddrW-1:0]   grant_q, grant_d;

  logic               cur_free;
  logic [SW-1:0]      cur_sz;
  logic [SW-1:0]      nxt;
  logic               fit;
  logic               better;
  logic [PagesW-1:0]  pages;
  logic [SW-1:0]      gran;
  logic [NeedW-1:0]   need_new;

  function automatic logic [SW-1:0] walk_next(logic [SW-1:0] g, logic [SW-1:0] sz,
                                              logic [SW-1:0] e);
    logic [SW-1:0] r;
    if (sz == '0 || sz > e - g) begin
      r = e;
    end else begin
      r = g + sz;
    end
    return r;
  endfunction

  assign cur_free = rdata_i[HW-1];
  assign cur_sz   = rdata_i[SW-1:0];
  assign nxt      = walk_next(g_q, cur_sz, end_q);
  assign fit      = cur_free && (32'(cur_sz) >= 32'(need_q));
  assign better   = !found_q ||
                    (style_q == FIT_BEST  && cur_sz < wsz_q) ||
                    (style_q == FIT_WORST && cur_sz > wsz_q);

  assign pages    = PagesW'((PagesW'(req_i.request_bytes) + PagesW'(7)) >> PageShift)
                    + PagesW'(1);
  assign gran     = SW'(pages << PageGranShift);
  assign need_new = NeedW'((PagesW'(req_i.request_bytes) + PagesW'(7)) >> GranShift)
                    + NeedW'(1);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.granted_address = grant_q;

  always_comb begin
    state_d  = state_q;
    need_d   = need_q;
    style_d  = style_q;
    target_d = target_q;
    g_d      = g_q;
    win_d    = win_q;
    wsz_d    = wsz_q;
    found_d  = found_q;
    prev_d   = prev_q;
    psz_d    = psz_q;
    pfree_d  = pfree_q;
    hprev_d  = hprev_q;
    tsz_d    = tsz_q;
    init_d   = init_q;
    end_d    = end_q;
    status_d = status_q;
    grant_d  = grant_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = '0;
    re_o     = 1'b0;
    raddr_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          need_d   = need_new;
          style_d  = req_i.fit_style;
          target_d = req_i.block_address - AddrW'(1);
          g_d      = '0;
          found_d  = 1'b0;
          hprev_d  = 1'b0;
          grant_d  = '0;
          state_d  = S_DONE;
          case (req_i.mode)
            MODE_INIT: begin
              if (init_q || req_i.request_bytes == '0 || 32'(pages) > MaxPages) begin
                status_d = ST_BAD_ARGS;
              end else begin
                we_o     = 1'b1;
                wdata_o  = {1'b1, gran};
                end_d    = gran;
                init_d   = 1'b1;
                status_d = ST_OK;
              end
            end
            MODE_ALLOC: begin
              if (!init_q) begin
                status_d = ST_NO_INIT;
              end else if (req_i.fit_style != FIT_FIRST && req_i.fit_style != FIT_BEST &&
                           req_i.fit_style != FIT_WORST) begin
                status_d = ST_NO_SPACE;
              end else begin
                re_o    = 1'b1;
                state_d = S_AL_WALK;
              end
            end
            MODE_FREE: begin
              if (!init_q) begin
                status_d = ST_NO_INIT;
              end else if (req_i.block_address == '0) begin
                status_d = ST_BAD_PTR;
              end else begin
                re_o    = 1'b1;
                state_d = S_FR_WALK;
              end
            end
            default: status_d = ST_BAD_ARGS;
          endcase
        end
      end
      S_AL_WALK: begin
        if (fit && style_q == FIT_FIRST) begin
          win_d   = g_q[AW-1:0];
          wsz_d   = cur_sz;
          state_d = S_AL_SPLIT;
        end else begin
          if (fit && better) begin
            win_d   = g_q[AW-1:0];
            wsz_d   = cur_sz;
            found_d = 1'b1;
          end
          g_d = nxt;
          if (nxt < end_q) begin
            re_o    = 1'b1;
            raddr_o = nxt[AW-1:0];
          end else if (found_d) begin
            state_d = S_AL_SPLIT;
          end else begin
            status_d = ST_NO_SPACE;
            state_d  = S_DONE;
          end
        end
      end
      S_AL_SPLIT: begin
        // if the winner is larger than needed, carve its tail off as a new free block
        if (32'(wsz_q) > 32'(need_q)) begin
          we_o    = 1'b1;
          waddr_o = AW'(32'(win_q) + 32'(need_q));
          wdata_o = {1'b1, SW'(32'(wsz_q) - 32'(need_q))};
        end
        state_d = S_AL_MARK;
      end
      S_AL_MARK: begin
        we_o     = 1'b1;
        waddr_o  = win_q;
        wdata_o  = {1'b0, SW'(need_q)};
        status_d = ST_OK;
        grant_d  = AddrW'({1'b0, win_q} + SW'(1));
        state_d  = S_DONE;
      end
      S_FR_WALK: begin
        if (32'(g_q) == 32'(target_q)) begin
          if (cur_free || cur_sz == '0) begin
            status_d = ST_BAD_PTR;
            state_d  = S_DONE;
          end else begin
            tsz_d = cur_sz;
            if (nxt < end_q) begin
              re_o    = 1'b1;
              raddr_o = nxt[AW-1:0];
              state_d = S_FR_NEXT;
            end else begin
              state_d = S_FR_WT;
            end
          end
        end else if (32'(g_q) > 32'(target_q)) begin
          status_d = ST_BAD_PTR;
          state_d  = S_DONE;
        end else begin
          prev_d  = g_q[AW-1:0];
          psz_d   = cur_sz;
          pfree_d = cur_free;
          hprev_d = 1'b1;
          g_d     = nxt;
          if (nxt < end_q) begin
            re_o    = 1'b1;
            raddr_o = nxt[AW-1:0];
          end else begin
            status_d = ST_BAD_PTR;
            state_d  = S_DONE;
          end
        end
      end
      S_FR_NEXT: begin
        if (cur_free) begin
          tsz_d = tsz_q + cur_sz;
        end
        state_d = S_FR_WT;
      end
      S_FR_WT: begin
        we_o    = 1'b1;
        waddr_o = AW'(target_q);
        wdata_o = {1'b1, tsz_q};
        if (hprev_q && pfree_q) begin
          state_d = S_FR_WP;
        end else begin
          status_d = ST_OK;
          state_d  = S_DONE;
        end
      end
      S_FR_WP: begin
        we_o     = 1'b1;
        waddr_o  = prev_q;
        wdata_o  = {1'b1, psz_q + tsz_q};
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    style_q  <= style_d;
    target_q <= target_d;
    g_q      <= g_d;
    win_q    <= win_d;
    wsz_q    <= wsz_d;
    found_q  <= found_d;
    prev_q   <= prev_d;
    psz_q    <= psz_d;
    pfree_q  <= pfree_d;
    hprev_q  <= hprev_d;
    tsz_q    <= tsz_d;
    status_q <= status_d;
    grant_q  <= grant_d;
  end

endmodule

@@ src/fit_policy_block_allocator.sv @@
// Channel   | Dir | Word                                          | Handshake
// s_axis    | in  | tuser: mode; tdata: bytes, fit style, address | tvalid/tready
// m_axis    | out | tdata: status, granted address                 | tvalid/tready
//
// Every request takes its own pass over the header memory: init writes one header,
// allocate walks the blocks and then splits and marks the winner, free walks the
// blocks up to the target and then writes the freed header and merges free neighbours.
// The header walk does one synchronous memory read per block.
// Reset clears the initialized flag and region end; headers are never read
// before they are written. A stalled m_axis holds the result in the output
// register; the next word is accepted meanwhile and finishes once it drains.
module fit_policy_block_allocator #(
  parameter int unsigned CapacityGranules = fpba_pkg::DefCapacityGranules,
  parameter int unsigned PageBytes        = fpba_pkg::DefPageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [19:0] request_bytes, [21:20] fit_style, [33:22] block_address, [39:34] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [14:3] granted_address, [15] zero
  output logic [15:0] m_axis_tdata_o
);
  import fpba_pkg::*;

  localparam int unsigned AW = $clog2(CapacityGranules);
  localparam int unsigned HW = AW + 2;

  req_t           req;
  res_t           res;
  logic           res_valid;
  logic           res_take;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [HW-1:0]  wdata, rdata;
  logic           m_valid_q, m_valid_d;
  res_t           m_data_q, m_data_d;

  // unpack the request word
  assign req.mode          = s_axis_tuser_i;
  assign req.request_bytes = s_axis_tdata_i[19:0];
  assign req.fit_style     = s_axis_tdata_i[21:20];
  assign req.block_address = s_axis_tdata_i[33:22];

  fpba_ctrl #(
    .CapacityGranules(CapacityGranules),
    .PageBytes       (PageBytes)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i(s_axis_tvalid_i),
    .req_i      (req),
    .req_ready_o(s_axis_tready_o),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  fpba_mem #(
    .Depth(CapacityGranules),
    .Width(HW)
  ) u_mem (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // output register: load when empty or draining this cycle
  assign res_take = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid && res_take) begin
      m_valid_d = 1'b1;
      m_data_d  = res;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_data_q};

endmodule

@@ src/fpba_checker.sv @@
module fpba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);
  import fpba_pkg::*;

  // a stalled response word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled response changed");

  // one request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  // only a successful request grants an address
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != ST_OK |-> m_axis_tdata_o[14:3] == '0)
    else $error("address granted on failure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] == ST_OK || m_axis_tdata_o[2:0] == ST_BAD_ARGS ||
      m_axis_tdata_o[2:0] == ST_NO_SPACE || m_axis_tdata_o[2:0] == ST_BAD_PTR ||
      m_axis_tdata_o[2:0] == ST_NO_INIT)
    else $error("undefined status code");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o
);
